>>> sv/pfpd_pkg.sv
`default_nettype none

package pfpd_pkg;

    localparam int unsigned NONCE_BYTES_DEFAULT = 12;
    localparam int unsigned TAG_BYTES_DEFAULT   = 16;

    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

    localparam logic [7:0] PREAMBLE_0 = 8'hAA;
    localparam logic [7:0] PREAMBLE_1 = 8'h55;
    localparam logic [7:0] FRAME_TYPE = 8'h02;

    typedef enum logic [2:0] {
        PH_HUNT1  = 3'd0,
        PH_HUNT2  = 3'd1,
        PH_TYPE   = 3'd2,
        PH_NONCE  = 3'd3,
        PH_LENHI  = 3'd4,
        PH_LENLO  = 3'd5,
        PH_CIPHER = 3'd6,
        PH_TAG    = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONCE  = 2'd0,
        KIND_CIPHER = 2'd1,
        KIND_TAG    = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

endpackage

`default_nettype wire

>>> sv/preamble_framed_packet_deframer_unit.sv
// Preamble-framed packet deframer.
// Input channel: in_valid / in_stall with rx_byte, one received serial byte
// per beat. Output channel: out_valid / out_stall with kind, data_byte,
// position, message_length and last_of_frame, at most one beat per input.
// Config channel: cfg_valid / cfg_ready with cfg_data, the maximum accepted
// ciphertext length; cfg_ready is always high, so a write is never refused.
// An input beat is captured in the input register and decoded into the
// result register once that one is empty or out_stall is low.
// Throughput: one byte per cycle while out_stall is low, set by the single
// pass of framing logic between the input and result registers.
// Bytes that carry no result (preamble, type, in-bound length) just update state.
// Reset clears the phase to the preamble hunt, the counters to zero, the
// maximum length to 1024 and both pipeline stages to empty.
// When the receiver stalls, the result register holds; the input register
// still fills, and in_stall rises only once both stages are occupied.
`default_nettype none

module preamble_framed_packet_deframer_unit #(
    parameter int unsigned NONCE_BYTES = pfpd_pkg::NONCE_BYTES_DEFAULT,
    parameter int unsigned TAG_BYTES   = pfpd_pkg::TAG_BYTES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input beat
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    // result beat
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       data_byte,
    output logic [15:0]      position,
    output logic [15:0]      message_length,
    output logic             last_of_frame,
    // configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    localparam logic [15:0] NONCE_LAST = 16'(NONCE_BYTES - 1);
    localparam logic [15:0] TAG_LAST   = 16'(TAG_BYTES - 1);

    // framing state
    pfpd_pkg::phase_t phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] max_len_reg;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // result stage
    logic              out_valid_reg;
    pfpd_pkg::kind_t   kind_reg, res_kind;
    logic [7:0]        data_reg, res_data;
    logic [15:0]       pos_reg, res_pos;
    logic [15:0]       mlen_reg, res_mlen;
    logic              last_reg, res_last;
    logic              res_valid;

    logic advance;   // input stage drains into the result register
    logic [16:0] pos_plus1;
    logic [15:0] len_full;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign cfg_ready = 1'b1;
    assign pos_plus1 = {1'b0, count_reg} + 17'd1;
    assign len_full  = {len_reg[7:0], in_byte_reg};

    // next-state logic
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        unique case (phase_reg)
            pfpd_pkg::PH_HUNT1:
            begin
                if (in_byte_reg == pfpd_pkg::PREAMBLE_0)
                    phase_next = pfpd_pkg::PH_HUNT2;
            end
            pfpd_pkg::PH_HUNT2:
            begin
                phase_next = (in_byte_reg == pfpd_pkg::PREAMBLE_1)
                           ? pfpd_pkg::PH_TYPE : pfpd_pkg::PH_HUNT1;
            end
            pfpd_pkg::PH_TYPE:
            begin
                if (in_byte_reg == pfpd_pkg::FRAME_TYPE)
                begin
                    phase_next = pfpd_pkg::PH_NONCE;
                    count_next = '0;
                end
                else
                    phase_next = pfpd_pkg::PH_HUNT1;
            end
            pfpd_pkg::PH_NONCE:
            begin
                count_next = pos_plus1[15:0];
                if (count_reg >= NONCE_LAST)
                    phase_next = pfpd_pkg::PH_LENHI;
            end
            pfpd_pkg::PH_LENHI:
            begin
                len_next   = {8'd0, in_byte_reg};
                phase_next = pfpd_pkg::PH_LENLO;
            end
            pfpd_pkg::PH_LENLO:
            begin
                len_next   = len_full;
                count_next = '0;
                if (len_full > max_len_reg)
                    phase_next = pfpd_pkg::PH_HUNT1;
                else if (len_full == 16'd0)
                    phase_next = pfpd_pkg::PH_TAG;
                else
                    phase_next = pfpd_pkg::PH_CIPHER;
            end
            pfpd_pkg::PH_CIPHER:
            begin
                count_next = pos_plus1[15:0];
                if (pos_plus1 >= {1'b0, len_reg})
                begin
                    phase_next = pfpd_pkg::PH_TAG;
                    count_next = '0;
                end
            end
            pfpd_pkg::PH_TAG:
            begin
                count_next = pos_plus1[15:0];
                if (count_reg >= TAG_LAST)
                begin
                    phase_next = pfpd_pkg::PH_HUNT1;
                    count_next = '0;
                end
            end
            default:
            begin
                phase_next = pfpd_pkg::PH_HUNT1;
            end
        endcase
    end

    // result logic
    always_comb
    begin
        res_valid = 1'b0;
        res_kind  = pfpd_pkg::KIND_NONCE;
        res_data  = in_byte_reg;
        res_pos   = count_reg;
        res_mlen  = len_reg;
        res_last  = 1'b0;
        unique case (phase_reg)
            pfpd_pkg::PH_NONCE:
            begin
                res_valid = 1'b1;
                res_mlen  = '0;
            end
            pfpd_pkg::PH_LENLO:
            begin
                // oversize frame: single rejection beat
                res_valid = (len_full > max_len_reg);
                res_kind  = pfpd_pkg::KIND_REJECT;
                res_data  = '0;
                res_pos   = '0;
                res_mlen  = len_full;
                res_last  = 1'b1;
            end
            pfpd_pkg::PH_CIPHER:
            begin
                res_valid = 1'b1;
                res_kind  = pfpd_pkg::KIND_CIPHER;
            end
            pfpd_pkg::PH_TAG:
            begin
                res_valid = 1'b1;
                res_kind  = pfpd_pkg::KIND_TAG;
                res_last  = (count_reg >= TAG_LAST);
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pfpd_pkg::PH_HUNT1;
            count_reg     <= '0;
            len_reg       <= '0;
            max_len_reg   <= pfpd_pkg::MAX_LEN_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_len_reg <= cfg_data;
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg && res_valid;
            if (advance && in_valid_reg)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                len_reg   <= len_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= rx_byte;
        if (advance && in_valid_reg && res_valid)
        begin
            kind_reg <= res_kind;
            data_reg <= res_data;
            pos_reg  <= res_pos;
            mlen_reg <= res_mlen;
            last_reg <= res_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign data_byte      = data_reg;
    assign position       = pos_reg;
    assign message_length = mlen_reg;
    assign last_of_frame  = last_reg;

    // checks
    a_reject_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == pfpd_pkg::KIND_REJECT |-> last_of_frame && data_byte == 8'd0)
        else $error("rejection beat malformed");

    a_nonce_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == pfpd_pkg::KIND_NONCE |-> message_length == 16'd0 && !last_of_frame)
        else $error("nonce beat carries length or last");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && in_valid_reg)
        else $error("input stalled with a free stage");

    a_tag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == pfpd_pkg::PH_TAG |-> count_reg <= TAG_LAST)
        else $error("tag counter overran");

endmodule

`default_nettype wire
